// ----- rtl/core/scph_pkg.sv -----
// ----------------------------------------------------------------------------
// scph_pkg: shared types, constants and tables for the spectrum column peak hold
// Holds the position-to-bin and bin-to-hue tables, the register map, the
// structs passed between the top level and the peak store, and small helpers.
// ----------------------------------------------------------------------------
package scph_pkg;

    localparam int POS_W     = 7;
    localparam int LVL_W     = 17;
    localparam int BIN_W     = 6;
    localparam int HUE_W     = 8;
    localparam int CNT_W     = 8;
    localparam int KEEP_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 17;
    localparam int NUM_POS   = 80;
    localparam int BIN_COUNT = 64;

    localparam logic [LVL_W-1:0] ONE_Q16    = LVL_W'(65536);
    localparam logic [BIN_W-1:0] BOOST_BINS = BIN_W'(16);

    localparam logic [CNT_W-1:0]  HOLD_RST   = CNT_W'(6);
    localparam logic [KEEP_W-1:0] KEEP_RST   = KEEP_W'(58982);
    localparam logic [LVL_W-1:0]  FLOOR_RST  = LVL_W'(655);
    localparam logic [LVL_W-1:0]  MARGIN_RST = LVL_W'(3277);
    localparam logic [HUE_W-1:0]  HUE_RST    = HUE_W'(0);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOLD_FRAMES = 3'd0,
        CFG_DECAY_KEEP  = 3'd1,
        CFG_PEAK_FLOOR  = 3'd2,
        CFG_PEAK_MARGIN = 3'd3,
        CFG_BASE_HUE    = 3'd4
    } cfg_idx_t;

    // Four piecewise-linear bands: 0..10, 11..25, 26..50 and 51..79.
    localparam logic [BIN_W-1:0] BIN_LUT [0:NUM_POS-1] = '{
        6'd0,  6'd0,  6'd1,  6'd2,  6'd2,  6'd3,  6'd4,  6'd5,  6'd5,  6'd6,
        6'd7,  6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16,
        6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd24, 6'd24, 6'd25, 6'd26,
        6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36,
        6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd46,
        6'd47, 6'd48, 6'd48, 6'd49, 6'd49, 6'd50, 6'd50, 6'd51, 6'd51, 6'd52,
        6'd52, 6'd53, 6'd54, 6'd54, 6'd55, 6'd55, 6'd56, 6'd56, 6'd57, 6'd57,
        6'd58, 6'd59, 6'd59, 6'd60, 6'd60, 6'd61, 6'd61, 6'd62, 6'd62, 6'd63
    };

    // Hue offset of each bin: floor(bin * 160 / 63).
    localparam logic [HUE_W-1:0] HUE_LUT [0:BIN_COUNT-1] = '{
        8'd0,   8'd2,   8'd5,   8'd7,   8'd10,  8'd12,  8'd15,  8'd17,
        8'd20,  8'd22,  8'd25,  8'd27,  8'd30,  8'd33,  8'd35,  8'd38,
        8'd40,  8'd43,  8'd45,  8'd48,  8'd50,  8'd53,  8'd55,  8'd58,
        8'd60,  8'd63,  8'd66,  8'd68,  8'd71,  8'd73,  8'd76,  8'd78,
        8'd81,  8'd83,  8'd86,  8'd88,  8'd91,  8'd93,  8'd96,  8'd99,
        8'd101, 8'd104, 8'd106, 8'd109, 8'd111, 8'd114, 8'd116, 8'd119,
        8'd121, 8'd124, 8'd126, 8'd129, 8'd132, 8'd134, 8'd137, 8'd139,
        8'd142, 8'd144, 8'd147, 8'd149, 8'd152, 8'd154, 8'd157, 8'd160
    };

    // Settings used by the peak store.
    typedef struct packed {
        logic [CNT_W-1:0]  hold;
        logic [KEEP_W-1:0] keep;
        logic [LVL_W-1:0]  floor_lvl;
    } pk_cfg_t;

    // One lookup-and-update request for the peak store.
    typedef struct packed {
        logic              vld;
        logic              in_range;
        logic [POS_W-1:0]  pos;
        logic [LVL_W-1:0]  level;
    } pk_req_t;

    // Q16 level (at most 1.0) to an 8-bit value: (v * 255) >> 16.
    function automatic logic [BYTE_W-1:0] q16_to_byte(input logic [LVL_W-1:0] v);
        logic [LVL_W+BYTE_W-1:0] scaled;
        scaled = {v, {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, v};
        return scaled[16 +: BYTE_W];
    endfunction

endpackage

// ----- rtl/core/scph_peak_core.sv -----
// ----------------------------------------------------------------------------
// scph_peak_core: per-position peak-hold store with exponential decay
// An 80-entry synchronous memory holds the peak and hold count of each
// position. Each request reads its entry into a register, then updates it and
// writes it back; a write to the entry being read is bypassed into the read.
// ----------------------------------------------------------------------------
module scph_peak_core
    import scph_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  pk_req_t          req,
    input  pk_cfg_t          cfg,
    output logic [LVL_W-1:0] peak_reg
);

    typedef struct packed {
        logic [LVL_W-1:0] peak;
        logic [CNT_W-1:0] cnt;
    } pk_entry_t;

    pk_entry_t          mem [0:NUM_POS-1];
    logic [NUM_POS-1:0] ent_vld_reg;

    pk_entry_t          rd_data_reg;
    logic               rd_vld_reg;

    logic               s1_vld_reg;
    logic               s1_in_range_reg;
    logic [POS_W-1:0]   s1_pos_reg;
    logic [LVL_W-1:0]   s1_level_reg;

    logic [LVL_W-1:0]        cur_peak;
    logic [CNT_W-1:0]        cur_cnt;
    logic [LVL_W+KEEP_W-1:0] prod;
    logic [LVL_W-1:0]        decayed;
    pk_entry_t               wr_data;
    logic                    wr_en;
    logic                    wr_hit;
    logic [LVL_W-1:0]        peak_next;

    assign wr_en  = s1_vld_reg & s1_in_range_reg;
    assign wr_hit = wr_en && (s1_pos_reg == req.pos);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg      <= 1'b0;
            s1_in_range_reg <= 1'b0;
            rd_vld_reg      <= 1'b0;
            ent_vld_reg     <= '0;
        end
        else
        begin
            s1_vld_reg      <= req.vld;
            s1_in_range_reg <= req.in_range;
            if (req.vld && req.in_range)
            begin
                rd_vld_reg <= wr_hit | ent_vld_reg[req.pos];
            end
            if (wr_en)
            begin
                ent_vld_reg[s1_pos_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.vld)
        begin
            s1_pos_reg   <= req.pos;
            s1_level_reg <= req.level;
        end
        if (req.vld && req.in_range)
        begin
            if (wr_hit)
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[req.pos];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[s1_pos_reg] <= wr_data;
        end
    end

    // An entry never written reads as zero peak and zero count.
    assign cur_peak = rd_vld_reg ? rd_data_reg.peak : '0;
    assign cur_cnt  = rd_vld_reg ? rd_data_reg.cnt  : '0;
    assign prod     = cur_peak * cfg.keep;
    assign decayed  = prod[KEEP_W +: LVL_W];

    always_comb
    begin
        wr_data.peak = cur_peak;
        wr_data.cnt  = cur_cnt;
        if (s1_level_reg >= cur_peak)
        begin
            wr_data.peak = s1_level_reg;
            wr_data.cnt  = cfg.hold;
        end
        else if (cur_cnt != '0)
        begin
            wr_data.cnt = cur_cnt - CNT_W'(1);
        end
        else if (decayed < cfg.floor_lvl)
        begin
            wr_data.peak = '0;
        end
        else
        begin
            wr_data.peak = decayed;
        end
    end

    assign peak_next = s1_in_range_reg ? wr_data.peak : '0;

    always_ff @(posedge clk)
    begin
        if (s1_vld_reg)
        begin
            peak_reg <= peak_next;
        end
    end

endmodule

// ----- rtl/core/spectrum_column_peak_hold.sv -----
// ----------------------------------------------------------------------------
// spectrum_column_peak_hold: strip position to bin, hue, level and peak hold
// Maps each strip position to a spectrum bin, boosts and saturates its level,
// and keeps a decaying held peak per position with a peak indicator.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle: busy never rises, so a
// transaction is accepted at every edge where start is high. Each result comes
// out on done for exactly one cycle, after the s1, s2 and output registers,
// in the order the transactions came in, and the receiver cannot
// hold it off. The rate of one per cycle is set by the read-modify-write of
// the per-position peak memory: it is read in the accept cycle, updated and
// written back in the next one, and a write to the position that is being
// read at the same edge is bypassed into the read, so the same position may
// arrive in consecutive cycles. Peak memory entries start at zero after reset
// through per-entry valid bits; no clearing pass is needed. Positions above
// 79 get the bin of position 79, leave the peak memory untouched and report a
// zero peak. Configuration writes are always accepted (cfg_ready is high) and
// should be made only while no transaction is in flight; indexes beyond the
// register map are ignored.
// ----------------------------------------------------------------------------
module spectrum_column_peak_hold
    import scph_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 start,
    output logic                 busy,
    input  logic [POS_W-1:0]     position,
    input  logic [LVL_W-1:0]     level_in,

    output logic                 done,
    output logic [BIN_W-1:0]     bin_index,
    output logic [HUE_W-1:0]     hue,
    output logic [LVL_W-1:0]     level_out,
    output logic [BYTE_W-1:0]    brightness,
    output logic [LVL_W-1:0]     peak_level,
    output logic [BYTE_W-1:0]    peak_brightness,
    output logic                 show_peak,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    // Configuration registers.
    logic [CNT_W-1:0]  hold_frames_reg;
    logic [KEEP_W-1:0] decay_keep_reg;
    logic [LVL_W-1:0]  peak_floor_reg;
    logic [LVL_W-1:0]  peak_margin_reg;
    logic [HUE_W-1:0]  base_hue_reg;

    // Accept stage.
    logic              accept;
    logic              in_range;
    logic [POS_W-1:0]  lut_pos;
    logic [BIN_W-1:0]  bin_next;
    logic [LVL_W:0]    boosted;
    logic [LVL_W-1:0]  lvl_next;

    // Pipeline registers behind the accept stage.
    logic              s1_vld_reg;
    logic [BIN_W-1:0]  s1_bin_reg;
    logic [LVL_W-1:0]  s1_lvl_reg;
    logic              s2_vld_reg;
    logic [BIN_W-1:0]  s2_bin_reg;
    logic [LVL_W-1:0]  s2_lvl_reg;

    logic [LVL_W-1:0]  s2_peak;
    logic [LVL_W:0]    lvl_plus_margin;
    logic              show_next;
    logic [HUE_W-1:0]  hue_next;

    pk_req_t           pk_req;
    pk_cfg_t           pk_cfg;

    // Output registers.
    logic              done_reg;
    logic [BIN_W-1:0]  bin_index_reg;
    logic [HUE_W-1:0]  hue_reg;
    logic [LVL_W-1:0]  level_out_reg;
    logic [BYTE_W-1:0] brightness_reg;
    logic [LVL_W-1:0]  peak_level_reg;
    logic [BYTE_W-1:0] peak_brightness_reg;
    logic              show_peak_reg;

    // The pipeline never stalls, so a new transaction is taken every cycle.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_frames_reg <= HOLD_RST;
            decay_keep_reg  <= KEEP_RST;
            peak_floor_reg  <= FLOOR_RST;
            peak_margin_reg <= MARGIN_RST;
            base_hue_reg    <= HUE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_HOLD_FRAMES: hold_frames_reg <= cfg_data[CNT_W-1:0];
                CFG_DECAY_KEEP:  decay_keep_reg  <= cfg_data[KEEP_W-1:0];
                CFG_PEAK_FLOOR:  peak_floor_reg  <= cfg_data[LVL_W-1:0];
                CFG_PEAK_MARGIN: peak_margin_reg <= cfg_data[LVL_W-1:0];
                CFG_BASE_HUE:    base_hue_reg    <= cfg_data[HUE_W-1:0];
                default:         ;
            endcase
        end
    end

    // Out-of-range positions borrow the bin of the outermost position.
    assign in_range = (position < POS_W'(NUM_POS));
    assign lut_pos  = in_range ? position : POS_W'(NUM_POS - 1);
    assign bin_next = BIN_LUT[lut_pos];

    // Low bins get a 1.5x boost (truncated), then the level saturates at 1.0.
    always_comb
    begin
        boosted = {1'b0, level_in};
        if (bin_next < BOOST_BINS)
        begin
            boosted = {1'b0, level_in} + {2'b00, level_in[LVL_W-1:1]};
        end
        if (boosted > {1'b0, ONE_Q16})
        begin
            lvl_next = ONE_Q16;
        end
        else
        begin
            lvl_next = boosted[LVL_W-1:0];
        end
    end

    assign pk_req.vld       = accept;
    assign pk_req.in_range  = in_range;
    assign pk_req.pos       = position;
    assign pk_req.level     = lvl_next;

    assign pk_cfg.hold      = hold_frames_reg;
    assign pk_cfg.keep      = decay_keep_reg;
    assign pk_cfg.floor_lvl = peak_floor_reg;

    scph_peak_core u_peak_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (pk_req),
        .cfg      (pk_cfg),
        .peak_reg (s2_peak)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= accept;
            s2_vld_reg <= s1_vld_reg;
            done_reg   <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_bin_reg <= bin_next;
            s1_lvl_reg <= lvl_next;
        end
        if (s1_vld_reg)
        begin
            s2_bin_reg <= s1_bin_reg;
            s2_lvl_reg <= s1_lvl_reg;
        end
    end

    // The peak is zero for out-of-range positions, so the compare stays low.
    assign lvl_plus_margin = {1'b0, s2_lvl_reg} + {1'b0, peak_margin_reg};
    assign show_next       = ({1'b0, s2_peak} > lvl_plus_margin);
    assign hue_next        = base_hue_reg + HUE_LUT[s2_bin_reg];

    always_ff @(posedge clk)
    begin
        if (s2_vld_reg)
        begin
            bin_index_reg       <= s2_bin_reg;
            hue_reg             <= hue_next;
            level_out_reg       <= s2_lvl_reg;
            brightness_reg      <= q16_to_byte(s2_lvl_reg);
            peak_level_reg      <= s2_peak;
            peak_brightness_reg <= q16_to_byte(s2_peak);
            show_peak_reg       <= show_next;
        end
    end

    assign done            = done_reg;
    assign bin_index       = bin_index_reg;
    assign hue             = hue_reg;
    assign level_out       = level_out_reg;
    assign brightness      = brightness_reg;
    assign peak_level      = peak_level_reg;
    assign peak_brightness = peak_brightness_reg;
    assign show_peak       = show_peak_reg;

    // Every result goes back to a matching accepted transaction.
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 3))
        else $error("result without a matching transaction");

    // The held peak never climbs above full scale.
    a_peak_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (peak_level <= ONE_Q16))
        else $error("held peak above full scale");

    // The indicator only shows when the peak lies above the level.
    a_show_above: assert property (@(posedge clk) disable iff (!rst_n)
        (done && show_peak) |-> (peak_level > level_out))
        else $error("peak indicator set with peak not above level");

endmodule

// ----- tb/scph_column_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scph_column_checker: predicts and checks every spectrum column result
// Watches the command, result and register write channels of the spectrum
// column peak hold block, keeps its own copy of the registers and the per
// position peak memory, and compares each result against the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module scph_column_checker
    import scph_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 start,
    input  logic                 busy,
    input  logic [POS_W-1:0]     position,
    input  logic [LVL_W-1:0]     level_in,

    input  logic                 done,
    input  logic [BIN_W-1:0]     bin_index,
    input  logic [HUE_W-1:0]     hue,
    input  logic [LVL_W-1:0]     level_out,
    input  logic [BYTE_W-1:0]    brightness,
    input  logic [LVL_W-1:0]     peak_level,
    input  logic [BYTE_W-1:0]    peak_brightness,
    input  logic                 show_peak,

    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,

    output int                   failures,
    output int                   results_owed
);

    typedef struct packed {
        logic [BIN_W-1:0]  bin;
        logic [HUE_W-1:0]  hue;
        logic [LVL_W-1:0]  level;
        logic [BYTE_W-1:0] bright;
        logic [LVL_W-1:0]  peak;
        logic [BYTE_W-1:0] peak_bright;
        logic              show;
    } column_view_t;

    logic [CNT_W-1:0]  hold_setting;
    logic [KEEP_W-1:0] keep_setting;
    logic [LVL_W-1:0]  floor_setting;
    logic [LVL_W-1:0]  margin_setting;
    logic [HUE_W-1:0]  hue_setting;

    logic [LVL_W-1:0]  held_peak [NUM_POS];
    logic [CNT_W-1:0]  hold_left [NUM_POS];

    column_view_t      pending_columns [$];
    column_view_t      wanted;
    column_view_t      seen;

    function automatic logic [BYTE_W-1:0] level_to_byte(input longint unsigned q16);
        longint unsigned clipped;
        clipped = (q16 > 65536) ? 65536 : q16;
        return BYTE_W'((clipped * 255) >> 16);
    endfunction

    function automatic string view_text(input column_view_t v);
        return $sformatf("bin %0d hue %0d level %0d bright %0d peak %0d pbright %0d show %0b",
                         v.bin, v.hue, v.level, v.bright, v.peak, v.peak_bright, v.show);
    endfunction

    // Works out one result and updates the peak memory for the position.
    function automatic column_view_t predict_column(input logic [POS_W-1:0] pos,
                                                    input logic [LVL_W-1:0] lvl);
        column_view_t    v;
        int unsigned     d;
        int unsigned     bin;
        int unsigned     boosted;
        longint unsigned pk;
        d = (pos > NUM_POS - 1) ? NUM_POS - 1 : pos;
        if (d <= 10)
            bin = d * 8 / 11;
        else if (d <= 25)
            bin = 8 + (d - 11) * 16 / 15;
        else if (d <= 50)
            bin = 24 + (d - 26) * 24 / 25;
        else
            bin = 48 + (d - 51) * 16 / 29;
        boosted = lvl;
        if (bin < 16)
            boosted = (boosted * 3) >> 1;
        if (boosted > 65536)
            boosted = 65536;
        pk = 0;
        v.show = 1'b0;
        if (pos < NUM_POS) begin
            pk = held_peak[pos];
            if (boosted >= pk) begin
                pk = boosted;
                hold_left[pos] = hold_setting;
            end
            else if (hold_left[pos] != 0) begin
                hold_left[pos] = hold_left[pos] - 1'b1;
            end
            else begin
                pk = (pk * keep_setting) >> 16;
                if (pk < floor_setting)
                    pk = 0;
            end
            held_peak[pos] = LVL_W'(pk);
            v.show = (pk > longint'(boosted) + margin_setting);
        end
        v.bin         = BIN_W'(bin);
        v.hue         = hue_setting + HUE_W'(bin * 160 / 63);
        v.level       = LVL_W'(boosted);
        v.bright      = level_to_byte(boosted);
        v.peak        = LVL_W'(pk);
        v.peak_bright = level_to_byte(pk);
        return v;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hold_setting   = HOLD_RST;
            keep_setting   = KEEP_RST;
            floor_setting  = FLOOR_RST;
            margin_setting = MARGIN_RST;
            hue_setting    = HUE_RST;
            foreach (held_peak[i])
            begin
                held_peak[i] = '0;
                hold_left[i] = '0;
            end
            pending_columns.delete();
            failures     <= 0;
            results_owed <= 0;
        end
        else begin
            // Results are checked before new predictions go in, so a result
            // can never be matched against a transaction of the same edge.
            if (done) begin
                seen.bin         = bin_index;
                seen.hue         = hue;
                seen.level       = level_out;
                seen.bright      = brightness;
                seen.peak        = peak_level;
                seen.peak_bright = peak_brightness;
                seen.show        = show_peak;
                if (pending_columns.size() == 0) begin
                    if (failures < 10)
                        $display("%0t: result with none outstanding: %s", $time,
                                 view_text(seen));
                    failures <= failures + 1;
                end
                else begin
                    wanted = pending_columns.pop_front();
                    if (seen !== wanted) begin
                        if (failures < 10)
                            $display("%0t: mismatch\n  expected %s\n  actual   %s", $time,
                                     view_text(wanted), view_text(seen));
                        failures <= failures + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_HOLD_FRAMES: hold_setting   = CNT_W'(cfg_data);
                    CFG_DECAY_KEEP:  keep_setting   = KEEP_W'(cfg_data);
                    CFG_PEAK_FLOOR:  floor_setting  = LVL_W'(cfg_data);
                    CFG_PEAK_MARGIN: margin_setting = LVL_W'(cfg_data);
                    CFG_BASE_HUE:    hue_setting    = HUE_W'(cfg_data);
                    default:         ;
                endcase
            end
            if (start && !busy)
                pending_columns.push_back(predict_column(position, level_in));
            results_owed <= pending_columns.size();
        end
    end

endmodule

// ----- tb/spectrum_column_peak_hold_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spectrum_column_peak_hold_test: stimulus and verdict for the column block
// Drives directed and random strip positions and levels through four phases
// of register settings and sender idling, while the checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module spectrum_column_peak_hold_test;
    import scph_pkg::*;

    // A run is stuck when this many cycles pass with no transaction on any
    // channel. The longest legitimate gap is a short run of sender idles.
    localparam int STALL_LIMIT = 2000;

    // Items per random phase; four phases plus the directed part make up
    // roughly 750 transactions.
    localparam int PHASE_ITEMS = 183;

    // Positions revisited often, one or two per bin band, so that held peaks
    // actually count down, decay and fall through the floor.
    localparam logic [POS_W-1:0] HOT_POSITIONS [6] = '{7'd0, 7'd9, 7'd18, 7'd40, 7'd65, 7'd79};

    // Levels at the edges of the boost and saturation arithmetic.
    localparam logic [LVL_W-1:0] EDGE_LEVELS [6] =
        '{17'd0, 17'd43690, 17'd43691, 17'd65535, 17'd65536, 17'd131071};

    logic                 clk = 1'b0;
    logic                 rst_n;

    logic                 start;
    logic                 busy;
    logic [POS_W-1:0]     position;
    logic [LVL_W-1:0]     level_in;

    logic                 done;
    logic [BIN_W-1:0]     bin_index;
    logic [HUE_W-1:0]     hue;
    logic [LVL_W-1:0]     level_out;
    logic [BYTE_W-1:0]    brightness;
    logic [LVL_W-1:0]     peak_level;
    logic [BYTE_W-1:0]    peak_brightness;
    logic                 show_peak;

    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    int                   failures;
    int                   results_owed;
    int                   sender_idle_pct;
    int                   quiet_cycles;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    spectrum_column_peak_hold dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .position        (position),
        .level_in        (level_in),
        .done            (done),
        .bin_index       (bin_index),
        .hue             (hue),
        .level_out       (level_out),
        .brightness      (brightness),
        .peak_level      (peak_level),
        .peak_brightness (peak_brightness),
        .show_peak       (show_peak),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    scph_column_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .position        (position),
        .level_in        (level_in),
        .done            (done),
        .bin_index       (bin_index),
        .hue             (hue),
        .level_out       (level_out),
        .brightness      (brightness),
        .peak_level      (peak_level),
        .peak_brightness (peak_brightness),
        .show_peak       (show_peak),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .failures        (failures),
        .results_owed    (results_owed)
    );

    // Watchdog: any accepted transaction on any channel restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("spectrum_column_peak_hold test failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one column transaction. All tasks enter and leave at a falling
    // edge. Idle cycles come first, with junk on the payload so that nothing
    // leaks from a cycle where start is low. Start stays high when the next
    // transaction follows directly, so it never drops and rises in one step.
    task automatic send_column(input logic [POS_W-1:0] pos, input logic [LVL_W-1:0] lvl);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start    = 1'b0;
            position = POS_W'($urandom);
            level_in = LVL_W'($urandom);
            @(negedge clk);
        end
        start    = 1'b1;
        position = pos;
        level_in = lvl;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stops sending and waits until every outstanding result has come back,
    // and then lets the pipeline settle.
    task automatic drain_results();
        start = 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    // One register write transaction; valid is left high for the next write.
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DAT_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Rewrites every register. Only called with nothing in flight.
    task automatic apply_settings(input int hold, input int keep, input int floor_lvl,
                                  input int margin, input int base);
        write_reg(CFG_HOLD_FRAMES, CFG_DAT_W'(hold));
        write_reg(CFG_DECAY_KEEP,  CFG_DAT_W'(keep));
        write_reg(CFG_PEAK_FLOOR,  CFG_DAT_W'(floor_lvl));
        write_reg(CFG_PEAK_MARGIN, CFG_DAT_W'(margin));
        write_reg(CFG_BASE_HUE,    CFG_DAT_W'(base));
        cfg_valid = 1'b0;
    endtask

    // Random traffic. Most transactions hit a handful of positions with
    // mostly falling levels, which walks the peak memory through hold,
    // decay and floor; the rest spread over the strip or fall off its end.
    task automatic run_random_columns(input int count);
        logic [POS_W-1:0] pos;
        logic [LVL_W-1:0] lvl;
        int               pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
                pos = HOT_POSITIONS[$urandom_range(5)];
            else if (pick < 90)
                pos = POS_W'($urandom_range(NUM_POS - 1));
            else
                pos = POS_W'($urandom_range(127, NUM_POS));
            pick = $urandom_range(99);
            if (pick < 15)
                lvl = LVL_W'($urandom_range(131071));
            else if (pick < 25)
                lvl = EDGE_LEVELS[$urandom_range(5)];
            else if (pick < 40)
                lvl = LVL_W'($urandom_range(65536, 30000));
            else
                lvl = LVL_W'($urandom_range(8000));
            send_column(pos, lvl);
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        position        = '0;
        level_in        = '0;
        cfg_valid       = 1'b0;
        cfg_index       = CFG_HOLD_FRAMES;
        cfg_data        = '0;
        sender_idle_pct = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed, under the reset settings: band edges of the position map,
        // the boost just below and at saturation, level extremes, and
        // positions past the end of the strip.
        send_column(7'd0,   17'd0);
        send_column(7'd10,  17'd131071);
        send_column(7'd11,  17'd43690);
        send_column(7'd15,  17'd43691);
        send_column(7'd25,  17'd65536);
        send_column(7'd26,  17'd65535);
        send_column(7'd50,  17'd1);
        send_column(7'd51,  17'd131071);
        send_column(7'd79,  17'd65536);
        send_column(7'd80,  17'd100000);
        send_column(7'd127, 17'd1);
        drain_results();

        // Directed peak sequence on one position, back to back: a new peak,
        // the hold counting down, a decay step, an equal level reloading the
        // hold, then a decay that drops below the floor and clears the peak.
        // A base hue near the top checks the hue wrap.
        apply_settings(2, 32768, 20000, 0, 250);
        send_column(7'd40, 17'd60000);
        send_column(7'd40, 17'd0);
        send_column(7'd40, 17'd0);
        send_column(7'd40, 17'd0);
        send_column(7'd40, 17'd30000);
        send_column(7'd40, 17'd100);
        send_column(7'd40, 17'd100);
        send_column(7'd40, 17'd100);
        send_column(7'd40, 17'd0);
        drain_results();

        // Phase one: no idling; no hold, slowest decay, no floor, widest
        // margin, top hue.
        apply_settings(0, 65535, 0, 65536, 255);
        run_random_columns(PHASE_ITEMS);
        drain_results();

        // Phase two: sender idle most of the time; short hold, mid decay.
        sender_idle_pct = 65;
        apply_settings(3, 45000, 2000, 0, 17);
        run_random_columns(PHASE_ITEMS);
        drain_results();

        // Phase three: moderate idling; longest hold, a decay that keeps
        // nothing and the highest floor.
        sender_idle_pct = 37;
        apply_settings(255, 0, 65536, 1000, 128);
        run_random_columns(PHASE_ITEMS);
        drain_results();

        // Phase four: no idling again, with random settings.
        sender_idle_pct = 0;
        apply_settings($urandom_range(5), $urandom_range(65535), $urandom_range(4000),
                       $urandom_range(8000), $urandom_range(255));
        run_random_columns(PHASE_ITEMS);
        drain_results();

        if (failures == 0 && results_owed == 0)
            $display("spectrum_column_peak_hold test passed");
        else
            $display("spectrum_column_peak_hold test failed");
        $finish;
    end

endmodule
